// File: hdl/hkv_pkg.sv
package hkv_pkg;

   // Table geometry.
   localparam int BUCKET_BITS = 8;
   localparam int WAYS        = 4;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int NBUCKETS    = 1 << BUCKET_BITS;
   localparam int FILL_W      = $clog2(WAYS + 1);
   localparam int SLOT_W      = $clog2(WAYS);
   localparam int COUNT_W     = $clog2(NBUCKETS * WAYS + 1);
   localparam int FUNC_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_W       = 4;

   // Function codes.
   localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
   localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_FIRST  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_END       = 2'd3;

   // One bucket as stored in one memory row.
   typedef struct packed {
      logic [FILL_W-1:0]                 fill;
      logic [WAYS-1:0][KEY_BITS-1:0]     keys;
      logic [WAYS-1:0][VALUE_BITS-1:0]   vals;
   } row_type;

endpackage

// File: hdl/hkv_if.sv
interface hkv_req_if;
   import hkv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [KEY_BITS-1:0]      key;
   logic [VALUE_BITS-1:0]    value;
   logic [BUCKET_BITS-1:0]   cursor_bucket;
   logic [SLOT_W-1:0]        cursor_slot;
   modport source (output valid, func, key, value, cursor_bucket, cursor_slot, input ready);
   modport sink (input valid, func, key, value, cursor_bucket, cursor_slot, output ready);
endinterface

interface hkv_rsp_if;
   import hkv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [VALUE_BITS-1:0]    found_value;
   logic [KEY_BITS-1:0]      found_key;
   logic [BUCKET_BITS-1:0]   next_bucket;
   logic [SLOT_W-1:0]        next_slot;
   logic [COUNT_W-1:0]       entry_count;
   modport source (output valid, status, found_value, found_key, next_bucket, next_slot,
                   entry_count, input ready);
   modport sink (input valid, status, found_value, found_key, next_bucket, next_slot,
                 entry_count, output ready);
endinterface

// File: hdl/hkv_ram.sv
module hkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/hashed_key_value_table_core.sv
// Lookup, set, remove and unused codes read the bucket row while the request is taken,
// then pass through the read state and present their result from the result registers.
// First and next read one further bucket row for each row passed over (up to 255).
// Clear sweeps all 256 bucket rows, one per cycle, then presents its result.
// One item is in flight at a time.
// Reset (synchronous) runs the same clearing pass; no transfer is taken meanwhile.
module hashed_key_value_table_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [hkv_pkg::CSR_W-1:0]     csr_wdata,
   hkv_req_if.sink                       req_ch,
   hkv_rsp_if.source                     rsp_ch
);
   import hkv_pkg::*;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ} state_type;

   state_type                state_ff, state_in;
   logic [CSR_W-1:0]         bb_ff;
   logic [FUNC_W-1:0]        op_ff, op_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [VALUE_BITS-1:0]    val_ff, val_in;
   logic [SLOT_W-1:0]        cs_ff, cs_in;
   logic [BUCKET_BITS-1:0]   addr_ff, addr_in;
   logic                     scan_ff, scan_in;
   logic                     clr_rsp_ff, clr_rsp_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic                     rv_ff, rv_in;
   logic [STATUS_W-1:0]      rst_ff, rst_in;
   logic [VALUE_BITS-1:0]    rval_ff, rval_in;
   logic [KEY_BITS-1:0]      rkey_ff, rkey_in;
   logic [BUCKET_BITS-1:0]   rbk_ff, rbk_in;
   logic [SLOT_W-1:0]        rsl_ff, rsl_in;

   logic                     accept;
   logic [BUCKET_BITS-1:0]   bmask;
   logic [BUCKET_BITS-1:0]   req_bk;
   logic [BUCKET_BITS-1:0]   raddr;
   logic                     we;
   row_type                  rd, wrow;
   logic                     found;
   logic [SLOT_W-1:0]        fslot;
   logic [FILL_W-1:0]        cs_next;

   hkv_ram #(.WIDTH($bits(row_type)), .DEPTH(NBUCKETS)) u_rows (
      .clock (clock),
      .we    (we),
      .waddr (addr_ff),
      .wdata (wrow),
      .raddr (raddr),
      .rdata (rd)
   );

   // Bucket index from the low key bits, with the register clamped to the table size.
   always_comb begin
      bmask = '1;
      if (bb_ff < CSR_W'(BUCKET_BITS)) begin
         bmask = BUCKET_BITS'((1 << bb_ff) - 1);
      end
      req_bk = req_ch.key[BUCKET_BITS-1:0] & bmask;
   end

   assign accept = (state_ff == S_IDLE) && req_ch.valid && (!rv_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ch.ready);

   // Search the bucket row for the key; lowest matching slot wins.
   always_comb begin
      found = 1'b0;
      fslot = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if ((FILL_W'(i) < rd.fill) && (rd.keys[i] == key_ff)) begin
            found = 1'b1;
            fslot = SLOT_W'(i);
         end
      end
      cs_next = FILL_W'(cs_ff) + FILL_W'(1);
   end

   // Sequencer: issue the row read, then modify and write back or scan onward.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      cs_in      = cs_ff;
      addr_in    = addr_ff;
      scan_in    = scan_ff;
      clr_rsp_in = clr_rsp_ff;
      cnt_in     = cnt_ff;
      rv_in      = rv_ff && !rsp_ch.ready;
      rst_in     = rst_ff;
      rval_in    = rval_ff;
      rkey_in    = rkey_ff;
      rbk_in     = rbk_ff;
      rsl_in     = rsl_ff;
      raddr      = addr_ff;
      we         = 1'b0;
      wrow       = rd;

      case (state_ff)
         S_CLEAR: begin
            we        = 1'b1;
            wrow      = '0;
            addr_in   = addr_ff + BUCKET_BITS'(1);
            if (addr_ff == BUCKET_BITS'(NBUCKETS - 1)) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  clr_rsp_in = 1'b0;
                  rv_in      = 1'b1;
                  rst_in     = STAT_OK;
                  rval_in    = '0;
                  rkey_in    = '0;
                  rbk_in     = '0;
                  rsl_in     = '0;
               end
            end
         end
         S_IDLE: begin
            raddr = req_bk;
            if (req_ch.func == FN_FIRST) begin
               raddr = '0;
            end else if (req_ch.func == FN_NEXT) begin
               raddr = req_ch.cursor_bucket;
            end
            if (accept) begin
               op_in   = req_ch.func;
               key_in  = req_ch.key;
               val_in  = req_ch.value;
               cs_in   = req_ch.cursor_slot;
               addr_in = raddr;
               scan_in = (req_ch.func == FN_FIRST);
               if (req_ch.func == FN_CLEAR) begin
                  state_in   = S_CLEAR;
                  addr_in    = '0;
                  clr_rsp_in = 1'b1;
                  cnt_in     = '0;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            rv_in    = 1'b1;
            rst_in   = STAT_OK;
            rval_in  = '0;
            rkey_in  = '0;
            rbk_in   = '0;
            rsl_in   = '0;
            case (op_ff)
               FN_LOOKUP: begin
                  if (found) begin
                     rval_in = rd.vals[fslot];
                     rkey_in = key_ff;
                  end else begin
                     rst_in = STAT_NOT_FOUND;
                  end
               end
               FN_SET: begin
                  if (found) begin
                     we               = 1'b1;
                     wrow.vals[fslot] = val_ff;
                  end else if (rd.fill >= FILL_W'(WAYS)) begin
                     rst_in = STAT_FULL;
                  end else begin
                     we   = 1'b1;
                     wrow.keys[rd.fill[SLOT_W-1:0]] = key_ff;
                     wrow.vals[rd.fill[SLOT_W-1:0]] = val_ff;
                     wrow.fill = rd.fill + FILL_W'(1);
                     cnt_in    = cnt_ff + COUNT_W'(1);
                  end
               end
               FN_REMOVE: begin
                  if (found) begin
                     we = 1'b1;
                     // Close the gap so the bucket keeps its insertion order.
                     for (int i = 0; i < WAYS - 1; i++) begin
                        if (SLOT_W'(i) >= fslot) begin
                           wrow.keys[i] = rd.keys[i + 1];
                           wrow.vals[i] = rd.vals[i + 1];
                        end
                     end
                     wrow.fill = rd.fill - FILL_W'(1);
                     cnt_in    = cnt_ff - COUNT_W'(1);
                  end else begin
                     rst_in = STAT_NOT_FOUND;
                  end
               end
               FN_FIRST, FN_NEXT: begin
                  if (scan_ff && (rd.fill != '0)) begin
                     rval_in = rd.vals[0];
                     rkey_in = rd.keys[0];
                     rbk_in  = addr_ff;
                  end else if (!scan_ff && (cs_next < rd.fill)) begin
                     rval_in = rd.vals[cs_next[SLOT_W-1:0]];
                     rkey_in = rd.keys[cs_next[SLOT_W-1:0]];
                     rbk_in  = addr_ff;
                     rsl_in  = cs_next[SLOT_W-1:0];
                  end else if (addr_ff == BUCKET_BITS'(NBUCKETS - 1)) begin
                     rst_in = STAT_END;
                  end else begin
                     // Move on to the next bucket row.
                     rv_in    = rv_ff && !rsp_ch.ready;
                     state_in = S_READ;
                     scan_in  = 1'b1;
                     addr_in  = addr_ff + BUCKET_BITS'(1);
                     raddr    = addr_in;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         bb_ff      <= CSR_W'(BUCKET_BITS);
         addr_ff    <= '0;
         scan_ff    <= 1'b0;
         clr_rsp_ff <= 1'b0;
         cnt_ff     <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr_we) begin
            bb_ff <= csr_wdata;
         end
         addr_ff    <= addr_in;
         scan_ff    <= scan_in;
         clr_rsp_ff <= clr_rsp_in;
         cnt_ff     <= cnt_in;
         rv_ff      <= rv_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      cs_ff   <= cs_in;
      rst_ff  <= rst_in;
      rval_ff <= rval_in;
      rkey_ff <= rkey_in;
      rbk_ff  <= rbk_in;
      rsl_ff  <= rsl_in;
   end

   assign rsp_ch.valid       = rv_ff;
   assign rsp_ch.status      = rst_ff;
   assign rsp_ch.found_value = rval_ff;
   assign rsp_ch.found_key   = rkey_ff;
   assign rsp_ch.next_bucket = rbk_ff;
   assign rsp_ch.next_slot   = rsl_ff;
   assign rsp_ch.entry_count = cnt_ff;

endmodule

// File: tb/sv/tb_hashed_key_value_table_core.sv
`timescale 1ns / 100ps

module tb_hashed_key_value_table_core;
   import hkv_pkg::*;

   // One request as queued for the driver.
   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
      logic [BUCKET_BITS-1:0] cursor_bucket;
      logic [SLOT_W-1:0]      cursor_slot;
   } request_type;

   // One response as predicted or observed.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_BITS-1:0]  found_value;
      logic [KEY_BITS-1:0]    found_key;
      logic [BUCKET_BITS-1:0] next_bucket;
      logic [SLOT_W-1:0]      next_slot;
      logic [COUNT_W-1:0]     entry_count;
   } response_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_W-1:0] csr_wdata;

   hkv_req_if req_ch ();
   hkv_rsp_if rsp_ch ();

   hashed_key_value_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source)
   );

   // Shadow copy of the table.
   logic [KEY_BITS-1:0]   shadow_keys [NBUCKETS][WAYS];
   logic [VALUE_BITS-1:0] shadow_vals [NBUCKETS][WAYS];
   int unsigned           shadow_fill [NBUCKETS];
   int unsigned           shadow_total;
   logic [CSR_W-1:0]      shadow_bits;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int        mismatch_count;
   int        rsp_count;
   int        ops_seen [8];
   bit        hold_go;
   bit        hold_rsp;
   bit        req_taken;
   bit        rsp_taken;
   int        req_gap;
   int        rsp_gap;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #200ms;
      $display("FAIL hashed_key_value_table_core");
      $finish;
   end

   // Long response hold-off, counted in cycles here once the stimulus asks for it.
   initial begin
      hold_rsp = 1'b0;
      wait (hold_go);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   function automatic int unsigned key_bucket(logic [KEY_BITS-1:0] key);
      int unsigned nbits;
      nbits = (shadow_bits > BUCKET_BITS) ? BUCKET_BITS : shadow_bits;
      return int'(key & ((32'd1 << nbits) - 1));
   endfunction

   function automatic int find_way(int unsigned bk, logic [KEY_BITS-1:0] key);
      for (int i = 0; i < shadow_fill[bk]; i++)
         if (shadow_keys[bk][i] == key) return i;
      return -1;
   endfunction

   function automatic int unsigned first_used_bucket(int unsigned start);
      for (int unsigned b = start; b < NBUCKETS; b++)
         if (shadow_fill[b] > 0) return b;
      return NBUCKETS;
   endfunction

   // Apply one request to the shadow table and return its response.
   function automatic response_type table_apply(request_type rq);
      response_type r;
      int unsigned bk, b, slot;
      int          w;
      bit          hit;
      r = '0;
      hit = 0;
      slot = 0;
      bk = key_bucket(rq.key);
      case (rq.func)
         FN_LOOKUP: begin
            w = find_way(bk, rq.key);
            if (w < 0) r.status = STAT_NOT_FOUND;
            else begin
               r.found_value = shadow_vals[bk][w];
               r.found_key = rq.key;
            end
         end
         FN_SET: begin
            w = find_way(bk, rq.key);
            if (w >= 0) shadow_vals[bk][w] = rq.value;
            else if (shadow_fill[bk] >= WAYS) r.status = STAT_FULL;
            else begin
               shadow_keys[bk][shadow_fill[bk]] = rq.key;
               shadow_vals[bk][shadow_fill[bk]] = rq.value;
               shadow_fill[bk]++;
               shadow_total++;
            end
         end
         FN_REMOVE: begin
            w = find_way(bk, rq.key);
            if (w < 0) r.status = STAT_NOT_FOUND;
            else begin
               for (int i = w; i + 1 < shadow_fill[bk]; i++) begin
                  shadow_keys[bk][i] = shadow_keys[bk][i+1];
                  shadow_vals[bk][i] = shadow_vals[bk][i+1];
               end
               shadow_fill[bk]--;
               shadow_total--;
            end
         end
         FN_FIRST: begin
            b = first_used_bucket(0);
            if (b < NBUCKETS) begin
               bk = b;
               hit = 1;
            end else r.status = STAT_END;
         end
         FN_NEXT: begin
            if (rq.cursor_slot + 1 < shadow_fill[rq.cursor_bucket]) begin
               bk = rq.cursor_bucket;
               slot = rq.cursor_slot + 1;
               hit = 1;
            end else begin
               b = first_used_bucket(rq.cursor_bucket + 1);
               if (b < NBUCKETS) begin
                  bk = b;
                  hit = 1;
               end else r.status = STAT_END;
            end
         end
         FN_CLEAR: begin
            foreach (shadow_fill[i]) shadow_fill[i] = 0;
            shadow_total = 0;
         end
         default: ;
      endcase
      if (hit) begin
         r.found_key = shadow_keys[bk][slot];
         r.found_value = shadow_vals[bk][slot];
         r.next_bucket = bk[BUCKET_BITS-1:0];
         r.next_slot = slot[SLOT_W-1:0];
      end
      r.entry_count = shadow_total[COUNT_W-1:0];
      return r;
   endfunction

   // Driver: offers queued requests with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_ch.valid && !req_taken) begin
         // Hold the offer.
      end else if (req_gap > 0) begin
         req_ch.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         request_type rq;
         rq = pending_reqs.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.func <= rq.func;
         req_ch.key <= rq.key;
         req_ch.value <= rq.value;
         req_ch.cursor_bucket <= rq.cursor_bucket;
         req_ch.cursor_slot <= rq.cursor_slot;
         req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Predict on every request transfer.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         request_type rq;
         rq.func = req_ch.func;
         rq.key = req_ch.key;
         rq.value = req_ch.value;
         rq.cursor_bucket = req_ch.cursor_bucket;
         rq.cursor_slot = req_ch.cursor_slot;
         ops_seen[rq.func]++;
         expected_rsps.push_back(table_apply(rq));
      end
   end

   // Response ready with random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            rsp_gap <= $urandom_range(0, 9);
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         response_type got, want;
         got.status = rsp_ch.status;
         got.found_value = rsp_ch.found_value;
         got.found_key = rsp_ch.found_key;
         got.next_bucket = rsp_ch.next_bucket;
         got.next_slot = rsp_ch.next_slot;
         got.entry_count = rsp_ch.entry_count;
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected response %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: response %0d expected %p got %p", rsp_count, want, got);
            end
         end
      end
   end

   // Build a random request; keys are mostly drawn from a small pool.
   function automatic request_type random_request(logic [KEY_BITS-1:0] pool[]);
      request_type rq;
      int unsigned pick;
      rq.value = $urandom;
      rq.cursor_bucket = BUCKET_BITS'($urandom);
      rq.cursor_slot = SLOT_W'($urandom);
      rq.key = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 40) rq.func = FN_SET;
      else if (pick < 60) rq.func = FN_LOOKUP;
      else if (pick < 78) rq.func = FN_REMOVE;
      else if (pick < 84) rq.func = FN_FIRST;
      else if (pick < 97) rq.func = FN_NEXT;
      else if (pick < 98) rq.func = FN_CLEAR;
      else rq.func = 3'($urandom_range(6, 7));
      return rq;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_bucket_bits(logic [CSR_W-1:0] bits);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= bits;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_bits = bits;
   endtask

   task automatic push(logic [FUNC_W-1:0] f, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v,
                       logic [BUCKET_BITS-1:0] cb = '0, logic [SLOT_W-1:0] cs = '0);
      pending_reqs.push_back({f, k, v, cb, cs});
   endtask

   // Stimulus.
   initial begin
      logic [KEY_BITS-1:0] pool[];
      logic [CSR_W-1:0]    phase_bits[6];
      request_type         rq;
      phase_bits = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd8};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.key = '0;
      req_ch.value = '0;
      req_ch.cursor_bucket = '0;
      req_ch.cursor_slot = '0;
      rsp_ch.ready = 1'b0;
      hold_go = 1'b0;
      mismatch_count = 0;
      rsp_count = 0;
      shadow_bits = 4'd8;
      shadow_total = 0;
      foreach (shadow_fill[i]) shadow_fill[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, extremes, full bucket, removal order, iteration.
      push(FN_FIRST, '0, '0);
      push(FN_NEXT, '0, '0, 8'hFF, 2'd3);
      push(FN_LOOKUP, '1, '0);
      push(FN_REMOVE, '0, '0);
      push(FN_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      push(FN_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      for (int i = 1; i <= 4; i++) push(FN_SET, 32'(i << 8) | 32'h10, 32'(i));
      push(FN_SET, 32'h0000_0510, 32'h55);
      push(FN_SET, 32'h0000_0210, 32'hAAAA_5555);
      push(FN_LOOKUP, 32'h0000_0210, '0);
      push(FN_REMOVE, 32'h0000_0210, '0);
      push(FN_FIRST, '0, '0);
      push(FN_NEXT, '1, '1, 8'h10, 2'd0);
      push(FN_NEXT, '0, '0, 8'h10, 2'd3);
      push(FN_NEXT, '0, '0, 8'hFF, 2'd0);
      push(FN_NEXT, '0, '0, 8'h00, 2'd2);
      push(3'd6, '1, '1);
      push(3'd7, '0, '0);
      push(FN_CLEAR, '0, '0);
      push(FN_FIRST, '0, '0);
      wait_drained();

      // Random phases over several register settings; entries kept across changes.
      foreach (phase_bits[p]) begin
         write_bucket_bits(phase_bits[p]);
         pool = new[($urandom_range(0, 1) == 0) ? 12 : 48];
         foreach (pool[i]) pool[i] = $urandom;
         for (int n = 0; n < 330; n++) begin
            rq = random_request(pool);
            pending_reqs.push_back(rq);
            if (p == 2 && n == 100) begin
               // Stall the response side long enough for the input to back up.
               while (pending_reqs.size() > 0) @(posedge clock);
               hold_go = 1'b1;
               for (int k = 0; k < 8; k++) push(FN_LOOKUP, pool[k], '0);
            end
            if (p == 3 && n == 150) wait_drained();
         end
         wait_drained();
      end

      $display("Covered %0d responses: lookup %0d, set %0d, remove %0d, first %0d, next %0d,",
               rsp_count, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4]);
      $display("clear %0d, unused codes %0d, across six bucket_bits settings.",
               ops_seen[5], ops_seen[6] + ops_seen[7]);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("PASS hashed_key_value_table_core");
      end else begin
         $display("FAIL hashed_key_value_table_core");
      end
      $finish;
   end

endmodule
